FILE: hw/rtl/iol_pkg.sv
// ----------------------------------------------------------------------------
// iol_pkg
// Shared types and codes of the indexed ordered list: item formats,
// command codes, status codes and controller states.
// ----------------------------------------------------------------------------
package iol_pkg;

    localparam int IOL_CAPACITY = 32;

    typedef logic signed [31:0] t_word;

    typedef enum logic [2:0] {
        OP_INSERT  = 3'd0,
        OP_ERASE   = 3'd1,
        OP_HEAD    = 3'd2,
        OP_TAIL    = 3'd3,
        OP_READ_AT = 3'd4,
        OP_DUMP    = 3'd5,
        OP_INDEX   = 3'd6
    } t_op;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [2:0]  op;
        logic [5:0]  position;
        t_word       item_value;
    } t_in_item;

    typedef struct packed {
        t_word       result_value;
        logic [1:0]  status;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic       load;
        t_out_item  item;
    } t_out_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOVE,
        S_INS_WR,
        S_READ,
        S_RESP
    } t_state;

endpackage

FILE: hw/rtl/indexed_ordered_list.sv
// ----------------------------------------------------------------------------
// indexed_ordered_list
// Ordered list of signed words with positional insert, erase and reads.
// ----------------------------------------------------------------------------
// one item in flight; the next item is taken once the last result is registered
// errors, index of and erase of the tail: result loaded from the response state
// head, tail and read at: one read, then the result; append: item written, then response
// insert: shift pos..tail up, write the item, respond; erase: shift entries past pos down
// dump of n elements: results follow one per cycle while not stalled; output stall holds all
// reset clears the count and control state; element memory is not cleared
module indexed_ordered_list
    import iol_pkg::*;
#(
    parameter int CAPACITY = IOL_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int AW = $clog2(CAPACITY);

    logic          r_out_valid, n_out_valid;
    t_out_item     r_out_item, n_out_item;
    logic          w_out_free;
    t_out_req      w_out_req;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    t_word         w_wr_data;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    t_word         w_rd_data;

    assign w_out_free = !r_out_valid || !i_out_stall;

    iol_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_out_free (w_out_free),
        .o_out_req  (w_out_req),
        .o_wr_en    (w_wr_en),
        .o_wr_addr  (w_wr_addr),
        .o_wr_data  (w_wr_data),
        .o_rd_en    (w_rd_en),
        .o_rd_addr  (w_rd_addr),
        .i_rd_data  (w_rd_data)
    );

    iol_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        if (w_out_req.load) begin
            n_out_valid = 1'b1;
            n_out_item  = w_out_req.item;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: hw/rtl/iol_store.sv
// ----------------------------------------------------------------------------
// iol_store
// Element memory: one write port and one read port, read data registered
// and held until the next read.
// ----------------------------------------------------------------------------
module iol_store
    import iol_pkg::*;
#(
    parameter int CAPACITY = IOL_CAPACITY
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [$clog2(CAPACITY)-1:0] i_wr_addr,
    input  t_word                       i_wr_data,
    input  logic                        i_rd_en,
    input  logic [$clog2(CAPACITY)-1:0] i_rd_addr,
    output t_word                       o_rd_data
);

    t_word r_mem [CAPACITY];
    t_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/iol_ctrl.sv
// ----------------------------------------------------------------------------
// iol_ctrl
// Command sequencer: decodes each item, walks the element memory to shift
// entries for insert and erase, and streams reads for head, tail, read at
// and dump.
// ----------------------------------------------------------------------------
module iol_ctrl
    import iol_pkg::*;
#(
    parameter int CAPACITY = IOL_CAPACITY
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  t_in_item                    i_in_item,
    output logic                        o_in_stall,
    input  logic                        i_out_free,
    output t_out_req                    o_out_req,
    output logic                        o_wr_en,
    output logic [$clog2(CAPACITY)-1:0] o_wr_addr,
    output t_word                       o_wr_data,
    output logic                        o_rd_en,
    output logic [$clog2(CAPACITY)-1:0] o_rd_addr,
    input  t_word                       i_rd_data
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 6) ? CW : 6;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [2:0]      r_op, n_op;
    logic [AW-1:0]   r_pos, n_pos;
    t_word           r_val, n_val;
    logic [AW-1:0]   r_ptr, n_ptr;
    logic [AW-1:0]   r_end, n_end;
    logic [AW-1:0]   r_wdst, n_wdst;
    logic            r_pend, n_pend;
    logic            r_pend_last, n_pend_last;
    logic            r_issued_all, n_issued_all;
    t_out_item       r_resp, n_resp;

    logic            w_accept;
    logic [CMPW-1:0] w_pos_x;
    logic [CMPW-1:0] w_cnt_x;
    logic            w_full;
    logic            w_empty;
    logic [AW-1:0]   w_pos_a;
    logic [AW-1:0]   w_last_a;
    logic            w_issue;
    logic            w_load_rd;

    assign w_accept  = i_in_valid && (r_state == S_IDLE);
    assign w_pos_x   = CMPW'(i_in_item.position);
    assign w_cnt_x   = CMPW'(r_count);
    assign w_full    = (r_count == CW'(CAPACITY));
    assign w_empty   = (r_count == '0);
    assign w_pos_a   = AW'(i_in_item.position);
    assign w_last_a  = AW'(r_count - CW'(1));
    assign w_issue   = ((r_state == S_MOVE) && !r_issued_all) ||
                       ((r_state == S_READ) && !r_issued_all && (!r_pend || i_out_free));
    assign w_load_rd = (r_state == S_READ) && r_pend && i_out_free;
    assign o_in_stall = (r_state != S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_in_item.op)
                        OP_INSERT: begin
                            if (w_pos_x > w_cnt_x || w_full) begin
                                n_state = S_RESP;
                            end else if (w_pos_x == w_cnt_x) begin
                                n_state = S_INS_WR;
                            end else begin
                                n_state = S_MOVE;
                            end
                        end
                        OP_ERASE: begin
                            if (w_pos_x >= w_cnt_x || w_pos_x == w_cnt_x - CMPW'(1)) begin
                                n_state = S_RESP;
                            end else begin
                                n_state = S_MOVE;
                            end
                        end
                        OP_HEAD, OP_TAIL, OP_DUMP: begin
                            n_state = w_empty ? S_RESP : S_READ;
                        end
                        OP_READ_AT: begin
                            n_state = (w_pos_x >= w_cnt_x) ? S_RESP : S_READ;
                        end
                        OP_INDEX: begin
                            n_state = S_RESP;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_MOVE: begin
                if (r_issued_all && !r_pend) begin
                    n_state = (r_op == OP_INSERT) ? S_INS_WR : S_RESP;
                end
            end
            S_INS_WR: begin
                n_state = S_RESP;
            end
            S_READ: begin
                if (w_load_rd && r_pend_last) begin
                    n_state = S_IDLE;
                end
            end
            S_RESP: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count      = r_count;
        n_op         = r_op;
        n_pos        = r_pos;
        n_val        = r_val;
        n_ptr        = r_ptr;
        n_end        = r_end;
        n_wdst       = r_wdst;
        n_pend       = r_pend;
        n_pend_last  = r_pend_last;
        n_issued_all = r_issued_all;
        n_resp       = r_resp;
        o_wr_en      = 1'b0;
        o_wr_addr    = r_wdst;
        o_wr_data    = i_rd_data;
        o_rd_en      = 1'b0;
        o_rd_addr    = r_ptr;
        o_out_req    = '0;

        if (w_accept) begin
            n_op         = i_in_item.op;
            n_pos        = w_pos_a;
            n_val        = i_in_item.item_value;
            n_pend       = 1'b0;
            n_issued_all = 1'b0;
            n_resp       = '{result_value: '0, status: ST_OK, last: 1'b1};
            case (i_in_item.op)
                OP_INSERT: begin
                    n_ptr = w_last_a;
                    n_end = w_pos_a;
                    if (w_pos_x > w_cnt_x) begin
                        n_resp.status = ST_RANGE;
                    end else if (w_full) begin
                        n_resp.status = ST_FULL;
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                end
                OP_ERASE: begin
                    n_ptr = AW'(w_pos_a + 1'b1);
                    n_end = w_last_a;
                    if (w_pos_x >= w_cnt_x) begin
                        n_resp.status = ST_RANGE;
                    end else begin
                        n_count = r_count - CW'(1);
                    end
                end
                OP_HEAD: begin
                    n_ptr = '0;
                    n_end = '0;
                    if (w_empty) begin
                        n_resp.status = ST_EMPTY;
                    end
                end
                OP_TAIL: begin
                    n_ptr = w_last_a;
                    n_end = w_last_a;
                    if (w_empty) begin
                        n_resp.status = ST_EMPTY;
                    end
                end
                OP_READ_AT: begin
                    n_ptr = w_pos_a;
                    n_end = w_pos_a;
                    if (w_pos_x >= w_cnt_x) begin
                        n_resp.status = ST_RANGE;
                    end
                end
                OP_DUMP: begin
                    n_ptr = '0;
                    n_end = w_last_a;
                    if (w_empty) begin
                        n_resp.status = ST_EMPTY;
                    end
                end
                OP_INDEX: begin
                    if (w_pos_x >= w_cnt_x) begin
                        n_resp.status = ST_RANGE;
                    end else begin
                        n_resp.result_value = 32'(i_in_item.position);
                    end
                end
                default: begin
                    n_resp = r_resp;
                end
            endcase
        end

        // walk: issue one read per cycle; reads wait while a pending result cannot go out
        if (w_issue) begin
            o_rd_en     = 1'b1;
            o_rd_addr   = r_ptr;
            n_pend      = 1'b1;
            n_pend_last = (r_ptr == r_end);
            n_wdst      = (r_op == OP_INSERT) ? AW'(r_ptr + 1'b1) : AW'(r_ptr - 1'b1);
            if (r_ptr == r_end) begin
                n_issued_all = 1'b1;
            end else if ((r_state == S_MOVE) && (r_op == OP_INSERT)) begin
                n_ptr = AW'(r_ptr - 1'b1);
            end else begin
                n_ptr = AW'(r_ptr + 1'b1);
            end
        end else if (r_state == S_MOVE || w_load_rd) begin
            n_pend = 1'b0;
        end

        // shifted entry lands one place over
        if (r_state == S_MOVE && r_pend) begin
            o_wr_en   = 1'b1;
            o_wr_addr = r_wdst;
            o_wr_data = i_rd_data;
        end

        if (r_state == S_INS_WR) begin
            o_wr_en   = 1'b1;
            o_wr_addr = r_pos;
            o_wr_data = r_val;
        end

        if (w_load_rd) begin
            o_out_req.load = 1'b1;
            o_out_req.item = '{result_value: i_rd_data, status: ST_OK, last: r_pend_last};
        end

        if (r_state == S_RESP && i_out_free) begin
            o_out_req.load = 1'b1;
            o_out_req.item = r_resp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_pend       <= 1'b0;
            r_issued_all <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_pend       <= n_pend;
            r_issued_all <= n_issued_all;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_pos       <= n_pos;
        r_val       <= n_val;
        r_ptr       <= n_ptr;
        r_end       <= n_end;
        r_wdst      <= n_wdst;
        r_pend_last <= n_pend_last;
        r_resp      <= n_resp;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_no_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr_en && o_rd_en) |-> (o_wr_addr != o_rd_addr))
        else $error("read and write to the same entry in one cycle");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_req.load |-> i_out_free)
        else $error("result loaded while output register busy");

    a_read_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rd_en && r_state == S_READ) |-> (CW'(o_rd_addr) < r_count))
        else $error("read beyond the end of the list");

endmodule
